// File: rtl/core/chunk_peer_availability_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunk availability scheduler checker.
// Each macro expands to one labeled concurrent assertion on clk with rst.
// ----------------------------------------------------------------------------
`ifndef CHUNK_PEER_AVAILABILITY_SCHEDULER_TOP_ASSERT_SVH
`define CHUNK_PEER_AVAILABILITY_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define CPAS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define CPAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cpas_pkg.sv
// ----------------------------------------------------------------------------
// cpas_pkg
// Item types, request codes, controller states and helpers shared by the
// chunk availability scheduler and its checker.
// ----------------------------------------------------------------------------
package cpas_pkg;

  // Request item as it arrives on the request channel.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  channel;
    logic [31:0] msg_file_tag;
    logic [31:0] chunk_bits;
    logic [7:0]  chunk_index;
    logic [7:0]  active_mask;
  } req_t;

  // Result item, one for every request item.
  typedef struct packed {
    logic        accepted;
    logic        reply_bitfield;
    logic [7:0]  bitfield_due_mask;
    logic        found;
    logic [4:0]  chosen_chunk;
    logic [2:0]  chosen_channel;
    logic        all_done;
    logic [5:0]  chunks_held;
  } res_t;

  // Request codes.
  localparam logic [2:0] REQ_BITFIELD = 3'd0;
  localparam logic [2:0] REQ_HAVE     = 3'd1;
  localparam logic [2:0] REQ_STATUS   = 3'd2;
  localparam logic [2:0] REQ_DONE     = 3'd3;
  localparam logic [2:0] REQ_SELECT   = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_HMOD,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // Number of set bits in one byte.
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/chunk_peer_availability_scheduler_top.sv
// ----------------------------------------------------------------------------
// chunk_peer_availability_scheduler_top
// Chunk availability table with least-loaded peer selection.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_ready with a req_t item; every request
//   gives exactly one res_t item on res_valid/res_ready. The file tag is
//   written through cfg_we/cfg_wdata; the user writes it only while the
//   block is idle, which the block itself does not enforce. The block works
//   on one item at a time. Status, local done and refused requests finish
//   straight from the decode state; a have reads its peer row and then
//   updates it; an accepted bitfield has its chunk count summed one byte a
//   cycle; a select reads one peer row a cycle from the row memory. The
//   next item is taken once the result is loaded into the output register.
//   Peer rows and their chunk counts live in a synchronous memory; a row
//   valid flag per channel makes a cleared or never written row read as zero.
//   Reset clears all maps, the done count, the file tag and the row valid
//   flags at once, with no clearing pass.
//   A stalled receiver holds the result in the output register; the block
//   still takes and works on one more item, then waits until the output
//   register is free.
// ----------------------------------------------------------------------------
module chunk_peer_availability_scheduler_top import cpas_pkg::*; #(
  parameter int CHUNK_COUNT   = 32,
  parameter int CHANNEL_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req_item,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int CW    = $clog2(CHUNK_COUNT + 1);
  localparam int CIW   = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int CH_AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CH_CW = $clog2(CHANNEL_COUNT + 1);
  localparam int BFW   = (CHUNK_COUNT < 32) ? CHUNK_COUNT : 32;
  localparam int MW    = CW + CHUNK_COUNT;

  // Index of the single set bit of a one-hot chunk vector.
  function automatic logic [CIW-1:0] onehot_index(input logic [CHUNK_COUNT-1:0] v);
    logic [CIW-1:0] idx;
    idx = '0;
    for (int i = 0; i < CHUNK_COUNT; i++) begin
      if (v[i]) begin
        idx = idx | CIW'(i);
      end
    end
    return idx;
  endfunction

  state_t state, state_next;

  // Control state.
  logic [31:0]              file_tag;
  logic [CHUNK_COUNT-1:0]   own;
  logic [CW-1:0]            done_count;
  logic [CHANNEL_COUNT-1:0] known;
  logic [CHANNEL_COUNT-1:0] sent;
  logic [CHANNEL_COUNT-1:0] link_active;
  logic [CHANNEL_COUNT-1:0] row_valid;
  logic [1:0]               cnt_step;
  logic [CH_CW-1:0]         scan_addr;
  logic                     rd_pend;
  logic                     best_found;

  // Payload registers.
  req_t                     req_r;
  logic [31:0]              bf_bits;
  logic [CW-1:0]            cnt_acc;
  logic [CH_AW-1:0]         rd_ch;
  logic [CHUNK_COUNT-1:0]   best_iso;
  logic [CW-1:0]            best_cnt;
  logic [CH_AW-1:0]         best_ch;
  res_t                     res_hold;

  // Row memory: chunk count above the chunk row, one entry per channel.
  logic [MW-1:0]            mem [CHANNEL_COUNT];
  logic [MW-1:0]            rd_data;
  logic [CH_AW-1:0]         rd_addr;
  logic                     mem_we;
  logic [MW-1:0]            mem_wdata;

  // Decoded request fields.
  logic [CH_AW-1:0]         ch_addr;
  logic                     ch_ok;
  logic                     idx_ok;
  logic [CHUNK_COUNT-1:0]   chunk_bit;

  // Per-operation terms.
  logic [CHANNEL_COUNT-1:0] st_act, st_clr, st_known, st_sent1, st_due;
  logic                     st_acc;
  logic                     ld_hit;
  logic [CW-1:0]            done_after;
  logic [3:0]               bf_pop;
  logic [CW-1:0]            bf_total;
  logic [CHUNK_COUNT-1:0]   h_row;
  logic [CW-1:0]            h_cnt;
  logic                     h_hit;
  logic [CHUNK_COUNT-1:0]   sel_row, sel_miss, sel_iso;
  logic [CW-1:0]            sel_cnt;
  logic                     sel_better;
  logic                     scan_done;
  logic                     fin;
  res_t                     fin_res;
  logic                     out_free;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !res_valid || res_ready;

  assign ch_addr   = CH_AW'(req_r.channel);
  assign ch_ok     = int'(req_r.channel) < CHANNEL_COUNT;
  assign idx_ok    = int'(req_r.chunk_index) < CHUNK_COUNT;
  assign chunk_bit = CHUNK_COUNT'(1) << req_r.chunk_index;

  // Channel status update: drop inactive channels, find who still needs ours.
  assign st_act   = CHANNEL_COUNT'(req_r.active_mask);
  assign st_clr   = ~st_act & (known | sent);
  assign st_known = known & ~st_clr;
  assign st_sent1 = sent & ~st_clr;
  assign st_due   = st_act & ~st_sent1;
  assign st_acc   = (st_act != link_active) || (st_clr != '0) || (st_due != '0);

  // Local completion.
  assign ld_hit     = idx_ok && ((own & chunk_bit) == '0);
  assign done_after = (state == ST_EXEC && req_r.req_type == REQ_DONE && ld_hit) ?
                      done_count + CW'(1) : done_count;

  // Bitfield chunk count, one byte a cycle.
  assign bf_pop   = popcount8(bf_bits[{cnt_step, 3'b000} +: 8]);
  assign bf_total = cnt_acc + CW'(bf_pop);

  // Have: the row read back, with a cleared row taken as zero.
  assign h_row = row_valid[ch_addr] ? rd_data[CHUNK_COUNT-1:0] : '0;
  assign h_cnt = row_valid[ch_addr] ? rd_data[MW-1:CHUNK_COUNT] : '0;
  assign h_hit = (h_row & chunk_bit) == '0;

  // Select: the lowest missing chunk of this peer as an isolated bit. A lower
  // isolated bit means a lower chunk; on the same chunk the smaller count wins
  // and a tie keeps the earlier channel.
  assign sel_row    = row_valid[rd_ch] ? rd_data[CHUNK_COUNT-1:0] : '0;
  assign sel_cnt    = row_valid[rd_ch] ? rd_data[MW-1:CHUNK_COUNT] : '0;
  assign sel_miss   = sel_row & ~own;
  assign sel_iso    = sel_miss & (~sel_miss + CHUNK_COUNT'(1));
  assign sel_better = rd_pend && link_active[rd_ch] && known[rd_ch] && (sel_miss != '0) &&
                      (!best_found || (sel_iso < best_iso) ||
                       ((sel_iso == best_iso) && (sel_cnt < best_cnt)));
  assign scan_done  = (scan_addr == CH_CW'(CHANNEL_COUNT));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory access and the finished result.
  always_comb begin
    state_next = state;
    rd_addr    = ch_addr;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    fin        = 1'b0;
    fin_res    = '0;
    fin_res.all_done    = (done_after >= CW'(CHUNK_COUNT));
    fin_res.chunks_held = 6'(done_after);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_r.req_type)
          REQ_BITFIELD: begin
            if (ch_ok && (req_r.msg_file_tag == file_tag) && !known[ch_addr]) begin
              state_next = ST_COUNT;
            end else begin
              fin = 1'b1;
            end
          end
          REQ_HAVE: begin
            if (ch_ok && idx_ok) begin
              state_next = ST_HMOD;
            end else begin
              fin = 1'b1;
            end
          end
          REQ_STATUS: begin
            fin = 1'b1;
            fin_res.accepted          = st_acc;
            fin_res.bitfield_due_mask = 8'(st_due);
          end
          REQ_DONE: begin
            fin = 1'b1;
            fin_res.accepted = ld_hit;
          end
          REQ_SELECT: begin
            if (done_count < CW'(CHUNK_COUNT)) begin
              state_next = ST_SCAN;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_COUNT: begin
        if (cnt_step == 2'd3) begin
          mem_we    = 1'b1;
          mem_wdata = {bf_total, CHUNK_COUNT'(bf_bits)};
          fin       = 1'b1;
          fin_res.accepted       = 1'b1;
          fin_res.reply_bitfield = 1'b1;
        end
      end
      ST_HMOD: begin
        fin = 1'b1;
        if (h_hit) begin
          mem_we    = 1'b1;
          mem_wdata = {h_cnt + CW'(1), h_row | chunk_bit};
          fin_res.accepted = 1'b1;
        end
      end
      ST_SCAN: begin
        rd_addr = scan_addr[CH_AW-1:0];
        if (scan_done && !rd_pend) begin
          fin = 1'b1;
          fin_res.found = best_found;
          if (best_found) begin
            fin_res.chosen_chunk   = 5'(onehot_index(best_iso));
            fin_res.chosen_channel = 3'(best_ch);
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_next = ST_HOLD;
    end
  end

  // Row memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ch_addr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Control state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_tag    <= '0;
      own         <= '0;
      done_count  <= '0;
      known       <= '0;
      sent        <= '0;
      link_active <= '0;
      row_valid   <= '0;
      cnt_step    <= '0;
      scan_addr   <= '0;
      rd_pend     <= 1'b0;
      best_found  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        file_tag <= cfg_wdata;
      end
      if (state == ST_HOLD && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt_step   <= '0;
          scan_addr  <= '0;
          rd_pend    <= 1'b0;
          best_found <= 1'b0;
        end
        ST_EXEC: begin
          if (req_r.req_type == REQ_STATUS) begin
            link_active <= st_act;
            known       <= st_known;
            sent        <= st_sent1 | st_due;
            row_valid   <= row_valid & ~st_clr;
          end
          if (req_r.req_type == REQ_DONE && ld_hit) begin
            own        <= own | chunk_bit;
            done_count <= done_after;
          end
        end
        ST_COUNT: begin
          cnt_step <= cnt_step + 2'd1;
          if (cnt_step == 2'd3) begin
            known[ch_addr]     <= 1'b1;
            sent[ch_addr]      <= 1'b1;
            row_valid[ch_addr] <= 1'b1;
          end
        end
        ST_HMOD: begin
          if (h_hit) begin
            row_valid[ch_addr] <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (!scan_done) begin
            scan_addr <= scan_addr + CH_CW'(1);
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (sel_better) begin
            best_found <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      req_r   <= req_item;
      bf_bits <= 32'(BFW'(req_item.chunk_bits));
      cnt_acc <= '0;
    end
    if (state == ST_COUNT) begin
      cnt_acc <= bf_total;
    end
    if (state == ST_SCAN) begin
      rd_ch <= scan_addr[CH_AW-1:0];
      if (sel_better) begin
        best_iso <= sel_iso;
        best_cnt <= sel_cnt;
        best_ch  <= rd_ch;
      end
    end
    if (fin) begin
      res_hold <= fin_res;
    end
    if (state == ST_HOLD && out_free) begin
      res_item <= res_hold;
    end
  end

endmodule

// File: rtl/core/cpas_checker.sv
// ----------------------------------------------------------------------------
// cpas_checker
// Port-level checks of the chunk availability scheduler, bound to its top.
// ----------------------------------------------------------------------------
`include "chunk_peer_availability_scheduler_top_assert.svh"

module cpas_checker import cpas_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res_item
);

  // Items taken but whose result has not been taken yet.
  logic [1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + 2'(req_valid && req_ready) - 2'(res_valid && res_ready);
    end
  end

  // A stalled result stays put.
  `CPAS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "result changed while stalled")

  // A result only ever answers an item that was taken.
  `CPAS_ASSERT_IMPL(a_res_has_item, res_valid, pend != 2'd0, "result without an outstanding item")

  // At most one result waiting and one item in work.
  `CPAS_ASSERT_IMPL(a_pend_bound, 1'b1, pend <= 2'd2, "too many items outstanding")

  // A select never finds a chunk once every chunk is held.
  `CPAS_ASSERT_IMPL(a_found_not_done, res_valid && res_item.found, !res_item.all_done, "found while all done")

endmodule

bind chunk_peer_availability_scheduler_top cpas_checker u_cpas_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);

// File: bench/chunk_peer_availability_scheduler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunk availability scheduler testbench
// Drives request items through the valid/ready request channel and checks
// every result item against a predictor of the peer table, the local chunk
// map and the least-loaded peer selection. It runs directed corner cases,
// random traffic under several idling mixes, a long receiver hold-off and
// a final local completion.
// ----------------------------------------------------------------------------
module chunk_peer_availability_scheduler_top_test;
  import cpas_pkg::*;

  localparam int CHUNKS         = 32;
  localparam int CHANNELS       = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_item = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res_item;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // Predicted block state.
  logic [31:0] shared_tag = '0;
  logic [31:0] own_map = '0;
  logic [31:0] peer_map [CHANNELS];
  logic [7:0]  peer_listed = '0;
  logic [7:0]  bitfield_given = '0;
  logic [7:0]  link_up = '0;
  logic [5:0]  held_count = '0;

  res_t pending_results [$];
  int   fail_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  chunk_peer_availability_scheduler_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_item (req_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      peer_map[c] = '0;
    end
  end

  // Apply one request to the predicted state and return the result it gives.
  function automatic res_t apply_request(input req_t r);
    res_t o;
    int   best;
    int   n;
    o = '0;
    case (r.req_type)
      REQ_BITFIELD: begin
        if (r.msg_file_tag == shared_tag && !peer_listed[r.channel]) begin
          peer_map[r.channel] = r.chunk_bits;
          peer_listed[r.channel] = 1'b1;
          bitfield_given[r.channel] = 1'b1;
          o.accepted = 1'b1;
          o.reply_bitfield = 1'b1;
        end
      end
      REQ_HAVE: begin
        if (r.chunk_index < CHUNKS && !peer_map[r.channel][r.chunk_index[4:0]]) begin
          peer_map[r.channel][r.chunk_index[4:0]] = 1'b1;
          o.accepted = 1'b1;
        end
      end
      REQ_STATUS: begin
        if (r.active_mask != link_up) o.accepted = 1'b1;
        link_up = r.active_mask;
        // Channels that went down lose everything they told us.
        for (int c = 0; c < CHANNELS; c++) begin
          if (!link_up[c] && (peer_listed[c] || bitfield_given[c])) begin
            peer_listed[c] = 1'b0;
            bitfield_given[c] = 1'b0;
            peer_map[c] = '0;
            o.accepted = 1'b1;
          end
        end
        o.bitfield_due_mask = link_up & ~bitfield_given;
        if (o.bitfield_due_mask != '0) o.accepted = 1'b1;
        bitfield_given = bitfield_given | o.bitfield_due_mask;
      end
      REQ_DONE: begin
        if (r.chunk_index < CHUNKS && !own_map[r.chunk_index[4:0]]) begin
          own_map[r.chunk_index[4:0]] = 1'b1;
          held_count = held_count + 6'd1;
          o.accepted = 1'b1;
        end
      end
      REQ_SELECT: begin
        // Lowest missing chunk first, then the eligible peer with fewest chunks.
        if (held_count < CHUNKS) begin
          for (int i = 0; i < CHUNKS && !o.found; i++) begin
            if (!own_map[i]) begin
              best = CHUNKS + 1;
              for (int c = 0; c < CHANNELS; c++) begin
                if (link_up[c] && peer_listed[c] && peer_map[c][i]) begin
                  n = $countones(peer_map[c]);
                  if (n < best) begin
                    best = n;
                    o.chosen_channel = 3'(c);
                    o.found = 1'b1;
                  end
                end
              end
              if (o.found) o.chosen_chunk = 5'(i);
            end
          end
        end
      end
      default: begin
      end
    endcase
    o.all_done = (held_count >= CHUNKS);
    o.chunks_held = held_count;
    return o;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  // Check each result item, record each request item and each tag write.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %p", $time, res_item);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("accepted", 32'(want.accepted), 32'(res_item.accepted));
          compare_field("reply_bitfield", 32'(want.reply_bitfield),
                        32'(res_item.reply_bitfield));
          compare_field("bitfield_due_mask", 32'(want.bitfield_due_mask),
                        32'(res_item.bitfield_due_mask));
          compare_field("found", 32'(want.found), 32'(res_item.found));
          compare_field("chosen_chunk", 32'(want.chosen_chunk),
                        32'(res_item.chosen_chunk));
          compare_field("chosen_channel", 32'(want.chosen_channel),
                        32'(res_item.chosen_channel));
          compare_field("all_done", 32'(want.all_done), 32'(res_item.all_done));
          compare_field("chunks_held", 32'(want.chunks_held),
                        32'(res_item.chunks_held));
        end
      end
      if (req_valid && req_ready) pending_results.push_back(apply_request(req_item));
      if (cfg_we) shared_tag = cfg_wdata;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one item, with random sender gaps, and wait until it is taken.
  task automatic send_item(input req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // Let every expected result arrive, then give the block time to settle.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_file_tag(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t make_req(input logic [2:0] kind, input logic [2:0] ch,
                                    input logic [31:0] tag, input logic [31:0] bits,
                                    input logic [7:0] index, input logic [7:0] mask);
    req_t r;
    r.req_type = kind;
    r.channel = ch;
    r.msg_file_tag = tag;
    r.chunk_bits = bits;
    r.chunk_index = index;
    r.active_mask = mask;
    return r;
  endfunction

  // Random request mix; most bitfields carry the right tag so peers get listed.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r = make_req(3'($urandom), 3'($urandom), $urandom, $urandom, 8'($urandom),
                 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 20) begin
      r.req_type = REQ_BITFIELD;
      if ($urandom_range(99) < 85) r.msg_file_tag = shared_tag;
      case ($urandom_range(2))
        0: r.chunk_bits = $urandom;
        1: r.chunk_bits = $urandom & $urandom;
        default: r.chunk_bits = $urandom & $urandom & $urandom;
      endcase
    end else if (pick < 45) begin
      r.req_type = REQ_HAVE;
      r.chunk_index = ($urandom_range(99) < 85) ? 8'($urandom_range(CHUNKS - 1))
                                                : 8'($urandom_range(255));
    end else if (pick < 55) begin
      r.req_type = REQ_STATUS;
      if ($urandom_range(1) == 0) r.active_mask = 8'($urandom | $urandom);
    end else if (pick < 61) begin
      // Local completions stay rare so the chunk map fills slowly.
      r.req_type = REQ_DONE;
      r.chunk_index = ($urandom_range(1) == 0) ? 8'($urandom_range(CHUNKS - 1))
                                               : 8'($urandom_range(255));
    end else if (pick < 96) begin
      r.req_type = REQ_SELECT;
    end else begin
      r.req_type = 3'(REQ_SELECT + 3'($urandom_range(3, 1)));
    end
    return r;
  endfunction

  // Corner cases of each request kind, with no idling.
  task automatic test_directed_cases();
    logic [31:0] tag;
    tag = 32'hFFFF_FFFF;
    idle_pct = 0;
    stall_pct = 0;
    write_file_tag(tag);
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_BITFIELD, 3'd0, tag, 32'hFFFF_FFFF, 8'd0, 8'd0));
    // A second bitfield on the same channel is refused.
    send_item(make_req(REQ_BITFIELD, 3'd0, tag, 32'h0000_0000, 8'd0, 8'd0));
    // Tag mismatch is refused.
    send_item(make_req(REQ_BITFIELD, 3'd1, 32'h0, 32'hFFFF_FFFF, 8'd0, 8'd0));
    send_item(make_req(REQ_BITFIELD, 3'd7, tag, 32'h8000_0001, 8'd0, 8'd0));
    send_item(make_req(REQ_HAVE, 3'd1, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_HAVE, 3'd1, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_HAVE, 3'd2, '0, '0, 8'd31, 8'd0));
    // Have indices past the last chunk are ignored.
    send_item(make_req(REQ_HAVE, 3'd3, '0, '0, 8'd32, 8'd0));
    send_item(make_req(REQ_HAVE, 3'd3, '0, '0, 8'd255, 8'd0));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_STATUS, 3'd0, '0, '0, 8'd0, 8'hFF));
    send_item(make_req(REQ_STATUS, 3'd0, '0, '0, 8'd0, 8'hFF));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_DONE, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_DONE, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_DONE, 3'd0, '0, '0, 8'd31, 8'd0));
    send_item(make_req(REQ_DONE, 3'd0, '0, '0, 8'd255, 8'd0));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    // Unused request codes only report the local status.
    for (int k = 1; k <= 3; k++) begin
      send_item(make_req(3'(REQ_SELECT + 3'(k)), 3'($urandom), $urandom, $urandom,
                         8'($urandom), 8'($urandom)));
    end
    send_item(make_req(REQ_STATUS, 3'd0, '0, '0, 8'd0, 8'h01));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_STATUS, 3'd0, '0, '0, 8'd0, 8'h00));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    drain_results();
  endtask

  // Random traffic under one idling mix and one file tag.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input logic [31:0] tag, input int count);
    write_file_tag(tag);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_item(random_request());
    drain_results();
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    repeat (40) send_item(random_request());
    drain_results();
  endtask

  // Complete every chunk locally; a select must then find nothing.
  task automatic test_completion();
    idle_pct = 34;
    stall_pct = 34;
    for (int i = CHUNKS - 1; i >= 0; i--) begin
      send_item(make_req(REQ_DONE, 3'($urandom), $urandom, $urandom, 8'(i),
                         8'($urandom)));
    end
    send_item(make_req(REQ_STATUS, 3'd0, '0, '0, 8'd0, 8'hFF));
    send_item(make_req(REQ_BITFIELD, 3'd3, shared_tag, 32'hFFFF_FFFF, 8'd0, 8'd0));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    send_item(make_req(REQ_DONE, 3'd0, '0, '0, 8'd5, 8'd0));
    send_item(make_req(REQ_SELECT, 3'd0, '0, '0, 8'd0, 8'd0));
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(0, 0, $urandom, 320);
    test_random_traffic(67, 0, 32'h0000_0000, 320);
    test_random_traffic(0, 67, 32'hFFFF_FFFF, 320);
    test_random_traffic(34, 34, $urandom, 320);
    test_backpressure();
    test_completion();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
